>>> rtl/exact_fit_reuse_stack_unit_macros.svh
// Assertion helpers shared by the stack unit modules.
`ifndef EXACT_FIT_REUSE_STACK_UNIT_MACROS_SVH
`define EXACT_FIT_REUSE_STACK_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define EFRS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define EFRS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  `EFRS_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)
`else
`define EFRS_ASSERT(label, clk, rst_n, prop, msg)
`define EFRS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/efrs_pkg.sv
`default_nettype none

package efrs_pkg;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned IDX_W       = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned ADDR_W  = 48;
  localparam int unsigned SIZE_W  = 32;
  localparam int unsigned COUNT_W = 7;

  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd2;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SIZE_W-1:0] size;
  } efrs_entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // capture request, clear result fields
    logic push;    // write the new entry on top, count up
    logic clear;   // empty the stack
    logic rd_top;  // read the newest entry
    logic rd_dn;   // step the scan one entry down
    logic rd_up;   // read the entry above the match
    logic take;    // record the matching entry as the result
    logic shift;   // move the entry above down into the gap
    logic dec;     // count down after a removal
  } efrs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic match;
    logic idx_zero;
    logic at_top;
    logic shift_last;
  } efrs_sts_t;

endpackage

`default_nettype wire

>>> rtl/efrs_ctrl.sv
`default_nettype none
`include "exact_fit_reuse_stack_unit_macros.svh"

module efrs_ctrl (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  input  wire logic [efrs_pkg::CMD_W-1:0] cmd_i,
  input  wire efrs_pkg::efrs_sts_t       sts_i,
  output efrs_pkg::efrs_cmd_t            cmd_o,
  output logic                           busy,
  output logic                           done_o
);
  import efrs_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  logic [1:0] state_q, state_d;
  logic       done_q, done_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    done_d  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          unique case (cmd_i)
            CMD_RELEASE: begin
              cmd_o.push = !sts_i.full;
              done_d     = 1'b1;
            end
            CMD_LOOKUP: begin
              if (sts_i.empty) begin
                done_d = 1'b1;
              end else begin
                cmd_o.rd_top = 1'b1;
                state_d      = ST_SCAN;
              end
            end
            CMD_CLEAR: begin
              cmd_o.clear = 1'b1;
              done_d      = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // The entry read last cycle is compared; the next read is issued now.
        if (sts_i.match) begin
          cmd_o.take = 1'b1;
          if (sts_i.at_top) begin
            cmd_o.dec = 1'b1;
            done_d    = 1'b1;
            state_d   = ST_IDLE;
          end else begin
            cmd_o.rd_up = 1'b1;
            state_d     = ST_SHIFT;
          end
        end else if (sts_i.idx_zero) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          cmd_o.rd_dn = 1'b1;
        end
      end
      ST_SHIFT: begin
        cmd_o.shift = 1'b1;
        if (sts_i.shift_last) begin
          cmd_o.dec = 1'b1;
          done_d    = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

  `EFRS_ASSERT_IMPL(a_done_not_busy, clk_i, rst_ni, done_o, !busy, "result while busy")
  `EFRS_ASSERT_IMPL(a_end_gives_result, clk_i, rst_ni, $fell(busy), done_q, "lookup ended without result")

endmodule

`default_nettype wire

>>> rtl/efrs_datapath.sv
`default_nettype none
`include "exact_fit_reuse_stack_unit_macros.svh"

module efrs_datapath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic [efrs_pkg::ADDR_W-1:0] block_addr_i,
  input  wire logic [efrs_pkg::SIZE_W-1:0] block_size_i,
  input  wire efrs_pkg::efrs_cmd_t         cmd_i,
  output efrs_pkg::efrs_sts_t              sts_o,
  output logic                             hit_o,
  output logic [efrs_pkg::ADDR_W-1:0]      found_addr_o,
  output logic                             stored_o,
  output logic [efrs_pkg::COUNT_W-1:0]     entry_count_o
);
  import efrs_pkg::*;

  efrs_entry_t mem [STACK_DEPTH];
  efrs_entry_t rdata_q;
  efrs_entry_t wr_entry;

  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  rd_addr;
  logic [SIZE_W-1:0] req_size_q;
  logic              hit_q, stored_q;
  logic [ADDR_W-1:0] found_addr_q;
  logic [CNT_W-1:0]  idx_ext;

  assign wr_entry = '{addr: block_addr_i, size: block_size_i};
  assign idx_ext  = CNT_W'(idx_q);

  always_comb begin
    priority if (cmd_i.rd_top) begin
      rd_addr = IDX_W'(count_q - CNT_W'(1));
    end else if (cmd_i.rd_dn) begin
      rd_addr = idx_q - IDX_W'(1);
    end else if (cmd_i.rd_up) begin
      rd_addr = idx_q + IDX_W'(1);
    end else begin
      // During a shift the entry two above the destination is fetched next.
      rd_addr = idx_q + IDX_W'(2);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      mem[count_q[IDX_W-1:0]] <= wr_entry;
    end else if (cmd_i.shift) begin
      mem[idx_q] <= rdata_q;
    end
    rdata_q <= mem[rd_addr];
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.push) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.dec) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.rd_top) begin
      idx_d = IDX_W'(count_q - CNT_W'(1));
    end else if (cmd_i.rd_dn) begin
      idx_d = idx_q - IDX_W'(1);
    end else if (cmd_i.shift) begin
      idx_d = idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      idx_q    <= '0;
      hit_q    <= 1'b0;
      stored_q <= 1'b0;
    end else begin
      count_q <= count_d;
      idx_q   <= idx_d;
      if (cmd_i.accept) begin
        hit_q    <= 1'b0;
        stored_q <= cmd_i.push;
      end else if (cmd_i.take) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_size_q   <= block_size_i;
      found_addr_q <= '0;
    end else if (cmd_i.take) begin
      found_addr_q <= rdata_q.addr;
    end
  end

  assign sts_o.empty      = (count_q == '0);
  assign sts_o.full       = (count_q == CNT_W'(STACK_DEPTH));
  assign sts_o.match      = (rdata_q.size == req_size_q);
  assign sts_o.idx_zero   = (idx_q == '0);
  assign sts_o.at_top     = ((idx_ext + CNT_W'(1)) == count_q);
  assign sts_o.shift_last = ((idx_ext + CNT_W'(2)) == count_q);

  assign hit_o         = hit_q;
  assign found_addr_o  = found_addr_q;
  assign stored_o      = stored_q;
  assign entry_count_o = COUNT_W'(count_q);

  `EFRS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= CNT_W'(STACK_DEPTH), "count above depth")
  `EFRS_ASSERT_IMPL(a_shift_in_range, clk_i, rst_ni, cmd_i.shift, (idx_ext + CNT_W'(1)) < count_q, "shift past top")

endmodule

`default_nettype wire

>>> rtl/exact_fit_reuse_stack_unit.sv
// Channel  | Ports                                      | Transfer
// ---------+--------------------------------------------+--------------------------
// command  | start, busy, cmd_i, block_addr_i,          | start high and busy low
//          | block_size_i                               |
// result   | done_o, hit_o, found_addr_o, stored_o,     | done_o high, one cycle
//          | entry_count_o                              |
//
// Release, clear and unused commands finish at the accepting edge: busy never rises
// and done_o is high in the next cycle. A lookup keeps busy high while it compares k
// entries from the top at one memory read per cycle and shifts the s entries above
// the match down, with k + s at most 127 for a depth of 64. done_o is high in the
// cycle in which busy falls. Reset empties the stack without a clearing pass; the
// receiver cannot stall.
`default_nettype none

module exact_fit_reuse_stack_unit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [efrs_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic [efrs_pkg::ADDR_W-1:0]  block_addr_i,
  input  wire logic [efrs_pkg::SIZE_W-1:0]  block_size_i,
  output logic                              done_o,
  output logic                              hit_o,
  output logic [efrs_pkg::ADDR_W-1:0]       found_addr_o,
  output logic                              stored_o,
  output logic [efrs_pkg::COUNT_W-1:0]      entry_count_o
);
  import efrs_pkg::*;

  efrs_cmd_t cmd;
  efrs_sts_t sts;

  efrs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .cmd_i  (cmd_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  efrs_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .block_addr_i  (block_addr_i),
    .block_size_i  (block_size_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .hit_o         (hit_o),
    .found_addr_o  (found_addr_o),
    .stored_o      (stored_o),
    .entry_count_o (entry_count_o)
  );

endmodule

`default_nettype wire
